[hdl/sse_pkg.sv]
// Package for the selection sort engine: data width, default capacity and
// the sequencer state type. No dependencies.
package sse_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT,
        S_SCAN_START,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_OUT_START,
        S_OUT
    } t_state;

endpackage

[hdl/sse_store.sv]
// Value store of the selection sort engine: one write port, one read port
// with registered read data. Depends on sse_pkg for the data width.
module sse_store #(
    parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF,
    parameter int IW        = $clog2(MAX_ITEMS)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [IW-1:0]             i_waddr,
    input  logic [sse_pkg::DATA_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [IW-1:0]             i_raddr,
    output logic [sse_pkg::DATA_W-1:0] o_rdata
);

    logic [sse_pkg::DATA_W-1:0] r_mem [MAX_ITEMS];
    logic [sse_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/selection_sort_engine.sv]
// Selection sort engine top level: load, in-place selection sort, drain.
// Depends on sse_pkg and sse_store.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  input   | in        | i_valid / o_ready  | i_value[31:0], i_last_item
//  output  | out       | o_valid / i_ready  | o_sorted_value[31:0], o_last_out, o_overflow
//
// Loading takes an input beat whenever i_valid is high. The sort uses one store
// read port and one comparator: for each position p of an n-entry batch it
// scans entries p to n-1, writes the minimum to p and, on a swap, the old value
// of p to the minimum's index; draining then reads the store out in order.
// Reset (synchronous, active low) empties the batch and clears the overflow flag.
// Input ready is high only while loading; output stalls hold the current beat.
module selection_sort_engine #(
    parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [31:0]         i_value,
    input  logic                       i_last_item,
    // output channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [31:0]         o_sorted_value,
    output logic                       o_last_out,
    output logic                       o_overflow
);

    localparam int IW = $clog2(MAX_ITEMS);      // store index width
    localparam int CW = $clog2(MAX_ITEMS + 1);  // fill count width
    localparam int DW = sse_pkg::DATA_W;

    sse_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;     // values stored in this batch
    logic          r_drop,  n_drop;      // a value found the store full
    logic [IW-1:0] r_pos,   n_pos;       // position being filled by the sort
    logic [CW-1:0] r_issue, n_issue;     // next address to read during a scan
    logic          r_rvalid, n_rvalid;   // read data returns this cycle
    logic [IW-1:0] r_rtag,  n_rtag;      // address of the returning read data
    logic [DW-1:0] r_min_val, n_min_val; // running minimum of the scan
    logic [IW-1:0] r_min_idx, n_min_idx; // its first index
    logic [DW-1:0] r_pos_val, n_pos_val; // value at the current position
    logic [IW-1:0] r_k,     n_k;         // output index

    // store ports
    logic          we;
    logic [IW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [IW-1:0] raddr;
    logic [DW-1:0] rdata;

    logic [IW-1:0] last_idx;
    logic          more_pos;
    logic          in_beat;
    logic          out_beat;

    sse_store #(
        .MAX_ITEMS (MAX_ITEMS),
        .IW        (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign last_idx = IW'(r_count - CW'(1));
    // another position remains once this one is done
    assign more_pos = (CW'(r_pos) + CW'(2)) < r_count;

    assign o_ready  = (r_state == sse_pkg::S_LOAD);
    assign o_valid  = (r_state == sse_pkg::S_OUT);
    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;

    // The output beat is the registered store read; it holds while stalled
    // because no new read is issued until the beat is taken.
    assign o_sorted_value = $signed(rdata);
    assign o_last_out     = (r_k == last_idx);
    assign o_overflow     = r_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sse_pkg::S_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_rvalid <= n_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_issue   <= n_issue;
        r_rtag    <= n_rtag;
        r_min_val <= n_min_val;
        r_min_idx <= n_min_idx;
        r_pos_val <= n_pos_val;
        r_k       <= n_k;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_drop    = r_drop;
        n_pos     = r_pos;
        n_issue   = r_issue;
        n_rvalid  = 1'b0;
        n_rtag    = r_rtag;
        n_min_val = r_min_val;
        n_min_idx = r_min_idx;
        n_pos_val = r_pos_val;
        n_k       = r_k;
        we        = 1'b0;
        waddr     = r_pos;
        wdata     = r_min_val;
        re        = 1'b0;
        raddr     = r_pos;

        unique case (r_state)
            sse_pkg::S_LOAD: begin
                if (in_beat) begin
                    // append while there is room, otherwise drop and flag
                    if (r_count < CW'(MAX_ITEMS)) begin
                        we      = 1'b1;
                        waddr   = IW'(r_count);
                        wdata   = i_value;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_item) begin
                        n_state = sse_pkg::S_SORT;
                    end
                end
            end
            sse_pkg::S_SORT: begin
                n_pos = '0;
                n_k   = '0;
                if (r_count > CW'(1)) begin
                    n_state = sse_pkg::S_SCAN_START;
                end else begin
                    n_state = sse_pkg::S_OUT_START;
                end
            end
            sse_pkg::S_SCAN_START: begin
                // read the current position first, it seeds the minimum
                re       = 1'b1;
                raddr    = r_pos;
                n_rvalid = 1'b1;
                n_rtag   = r_pos;
                n_issue  = CW'(r_pos) + CW'(1);
                n_state  = sse_pkg::S_SCAN;
            end
            sse_pkg::S_SCAN: begin
                // issue the next read while comparing the returning one
                if (r_issue < r_count) begin
                    re       = 1'b1;
                    raddr    = IW'(r_issue);
                    n_rvalid = 1'b1;
                    n_rtag   = IW'(r_issue);
                    n_issue  = r_issue + CW'(1);
                end
                if (r_rvalid) begin
                    if (r_rtag == r_pos) begin
                        n_min_val = rdata;
                        n_min_idx = r_pos;
                        n_pos_val = rdata;
                    end else if ($signed(rdata) < $signed(r_min_val)) begin
                        // strict less keeps the first minimum
                        n_min_val = rdata;
                        n_min_idx = r_rtag;
                    end
                    if (r_rtag == last_idx) begin
                        n_state  = sse_pkg::S_SWAP_A;
                        n_rvalid = 1'b0;
                    end
                end
            end
            sse_pkg::S_SWAP_A: begin
                if (r_min_idx != r_pos) begin
                    we      = 1'b1;
                    waddr   = r_pos;
                    wdata   = r_min_val;
                    n_state = sse_pkg::S_SWAP_B;
                end else if (more_pos) begin
                    n_pos   = r_pos + IW'(1);
                    n_state = sse_pkg::S_SCAN_START;
                end else begin
                    n_state = sse_pkg::S_OUT_START;
                end
            end
            sse_pkg::S_SWAP_B: begin
                we    = 1'b1;
                waddr = r_min_idx;
                wdata = r_pos_val;
                if (more_pos) begin
                    n_pos   = r_pos + IW'(1);
                    n_state = sse_pkg::S_SCAN_START;
                end else begin
                    n_state = sse_pkg::S_OUT_START;
                end
            end
            sse_pkg::S_OUT_START: begin
                re      = 1'b1;
                raddr   = '0;
                n_k     = '0;
                n_state = sse_pkg::S_OUT;
            end
            sse_pkg::S_OUT: begin
                if (out_beat) begin
                    if (r_k == last_idx) begin
                        // batch done: empty the store and drop the flag
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = sse_pkg::S_LOAD;
                    end else begin
                        re    = 1'b1;
                        raddr = r_k + IW'(1);
                        n_k   = r_k + IW'(1);
                    end
                end
            end
            default: begin
                n_state = sse_pkg::S_LOAD;
            end
        endcase
    end

endmodule
